/* hdl/double_ended_queue_macros.svh */
// Assertion macros shared by the double-ended queue checker.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define DQ_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define DQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

/* hdl/dq_pkg.sv */
// Package: sizes, operation and status codes, controller/datapath interface types.
package dq_pkg;

    // Ring capacity and derived widths
    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STAT_W   = 2;

    localparam logic [IDX_W:0]   CAP_EXT  = (IDX_W + 1)'(CAPACITY);
    localparam logic [IDX_W-1:0] IDX_MAX  = IDX_W'(CAPACITY - 1);
    localparam logic [IDX_W-1:0] IDX_ZERO = '0;
    localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ZERO = '0;
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LIST       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_LIST
    } dq_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic              push_front;
        logic              push_back;
        logic              pop_front;
        logic              pop_back;
        logic              list_clear;
        logic              list_step;
        logic              use_list_offset;
        logic              load_result;
        logic              load_element;
        logic [STAT_W-1:0] status;
        logic              last;
        logic              out_clear;
    } dq_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic list_last;
        logic out_valid;
    } dq_stat_t;

endpackage

/* hdl/dq_ctrl.sv */
// Controller: decodes operations, sequences listings, manages the result handshake.
module dq_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [dq_pkg::MODE_W-1:0]   s_mode,
    input  logic                        m_ready,
    input  dq_pkg::dq_stat_t            stat,
    output dq_pkg::dq_cmd_t             cmd
);
    import dq_pkg::*;

    dq_state_t state_reg, state_next;
    logic      out_free;
    logic      accept;

    // Result register can take a new result this cycle
    assign out_free = !stat.out_valid || m_ready;
    assign accept   = s_valid && s_ready;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept && s_mode == MODE_LIST && !stat.empty) begin
                    state_next = S_LIST;
                end
            end
            S_LIST: begin
                if (out_free && stat.list_last) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        cmd           = '0;
        cmd.out_clear = m_ready;
        s_ready       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = out_free;
                // transaction taken this cycle (s_ready equals out_free here)
                if (s_valid && out_free) begin
                    case (s_mode)
                        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                            cmd.load_result = 1'b1;
                            cmd.last        = 1'b1;
                            if (stat.full) begin
                                cmd.status = ST_OVERFLOW;
                            end else begin
                                cmd.status     = ST_OK;
                                cmd.push_front = (s_mode == MODE_PUSH_FRONT);
                                cmd.push_back  = (s_mode == MODE_PUSH_BACK);
                            end
                        end
                        MODE_POP_FRONT, MODE_POP_BACK: begin
                            cmd.load_result = 1'b1;
                            cmd.last        = 1'b1;
                            if (stat.empty) begin
                                cmd.status = ST_UNDERFLOW;
                            end else begin
                                cmd.status    = ST_OK;
                                cmd.pop_front = (s_mode == MODE_POP_FRONT);
                                cmd.pop_back  = (s_mode == MODE_POP_BACK);
                            end
                        end
                        MODE_LIST: begin
                            if (stat.empty) begin
                                cmd.load_result = 1'b1;
                                cmd.last        = 1'b1;
                                cmd.status      = ST_EMPTY;
                            end else begin
                                cmd.list_clear = 1'b1;
                            end
                        end
                        default: begin
                            // undefined operation codes are dropped
                        end
                    endcase
                end
            end
            S_LIST: begin
                if (out_free) begin
                    cmd.load_result     = 1'b1;
                    cmd.load_element    = 1'b1;
                    cmd.use_list_offset = 1'b1;
                    cmd.list_step       = 1'b1;
                    cmd.status          = ST_OK;
                    cmd.last            = stat.list_last;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/dq_datapath.sv */
// Datapath: ring memory, head index, fill count, listing index and result register.
module dq_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic signed [dq_pkg::DATA_W-1:0]   s_value,
    input  dq_pkg::dq_cmd_t                    cmd,
    output dq_pkg::dq_stat_t                   stat,
    output logic                               m_valid,
    output logic signed [dq_pkg::DATA_W-1:0]   m_element,
    output logic [dq_pkg::STAT_W-1:0]          m_status,
    output logic                               m_last
);
    import dq_pkg::*;

    logic signed [DATA_W-1:0] mem [CAPACITY];

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] element_reg;
    logic [STAT_W-1:0] status_reg;
    logic              last_reg;

    logic [IDX_W-1:0]  head_dec;
    logic [IDX_W-1:0]  head_inc;
    logic [IDX_W-1:0]  offset;
    logic [IDX_W:0]    sum_wide;
    logic [IDX_W-1:0]  ring_addr;
    logic [IDX_W-1:0]  wr_addr;
    logic              mem_we;

    // Head neighbors with wrap
    assign head_dec = (head_reg == IDX_ZERO) ? IDX_MAX : head_reg - IDX_ONE;
    assign head_inc = (head_reg == IDX_MAX) ? IDX_ZERO : head_reg + IDX_ONE;

    // Ring address head + offset, one compare and subtract
    assign offset    = cmd.use_list_offset ? idx_reg : count_reg[IDX_W-1:0];
    assign sum_wide  = {1'b0, head_reg} + {1'b0, offset};
    assign ring_addr = (sum_wide >= CAP_EXT) ? IDX_W'(sum_wide - CAP_EXT)
                                             : sum_wide[IDX_W-1:0];

    assign mem_we  = cmd.push_front || cmd.push_back;
    assign wr_addr = cmd.push_front ? head_dec : ring_addr;

    // Status toward the controller
    assign stat.empty     = (count_reg == CNT_ZERO);
    assign stat.full      = (count_reg >= CNT_FULL);
    assign stat.list_last = ((CNT_W'(idx_reg) + CNT_ONE) == count_reg);
    assign stat.out_valid = out_valid_reg;

    // Pointer, count, listing index and result valid updates
    always_comb begin
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (cmd.push_front) begin
            head_next  = head_dec;
            count_next = count_reg + CNT_ONE;
        end else if (cmd.push_back) begin
            count_next = count_reg + CNT_ONE;
        end else if (cmd.pop_front) begin
            head_next  = head_inc;
            count_next = count_reg - CNT_ONE;
        end else if (cmd.pop_back) begin
            count_next = count_reg - CNT_ONE;
        end
        if (cmd.list_clear) begin
            idx_next = IDX_ZERO;
        end else if (cmd.list_step) begin
            idx_next = idx_reg + IDX_ONE;
        end
        if (cmd.load_result) begin
            out_valid_next = 1'b1;
        end else if (cmd.out_clear) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= IDX_ZERO;
            count_reg     <= CNT_ZERO;
            idx_reg       <= IDX_ZERO;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Ring memory write port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= s_value;
        end
    end

    // Result register; element comes from the registered memory read, or is zero when no element is loaded
    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            element_reg <= cmd.load_element ? mem[ring_addr] : '0;
            status_reg  <= cmd.status;
            last_reg    <= cmd.last;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_element = element_reg;
    assign m_status  = status_reg;
    assign m_last    = last_reg;

endmodule

/* hdl/double_ended_queue.sv */
// Top level: double-ended queue of signed 32-bit values on a ring memory.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_mode[2:0], s_value[31:0]
//  m_      | out       | m_valid / m_ready  | m_element[31:0], m_status[1:0], m_last
//
// Push and pop: the result is registered and appears in the cycle after acceptance.
// Listing of N elements: after acceptance, the elements follow one per cycle while
// the result register is free, through the single memory read port; s_ready stays low meanwhile.
// Result register stalls on m_ready; a new transaction is taken while the last
// result is being consumed. Reset (synchronous, aresetn low) empties the queue.
module double_ended_queue (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [dq_pkg::MODE_W-1:0]          s_mode,
    input  logic signed [dq_pkg::DATA_W-1:0]   s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [dq_pkg::DATA_W-1:0]   m_element,
    output logic [dq_pkg::STAT_W-1:0]          m_status,
    output logic                               m_last
);
    import dq_pkg::*;

    dq_cmd_t  cmd;
    dq_stat_t stat;

    // Control
    dq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Storage and result path
    dq_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_value   (s_value),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_element (m_element),
        .m_status  (m_status),
        .m_last    (m_last)
    );

endmodule

/* hdl/dq_checker.sv */
// Port-level checker for the double-ended queue, bound to the top level.
`include "double_ended_queue_macros.svh"

module dq_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic [dq_pkg::MODE_W-1:0]          s_mode,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [dq_pkg::DATA_W-1:0]   m_element,
    input logic [dq_pkg::STAT_W-1:0]          m_status,
    input logic                               m_last
);
    import dq_pkg::*;

    logic                     push_take;
    logic                     out_stall;
    logic                     err_out;
    logic                     list_mid;
    logic [DATA_W+STAT_W:0]   out_payload;

    // Handshake and result views used by the checks
    assign push_take   = s_valid && s_ready &&
                         (s_mode == MODE_PUSH_FRONT || s_mode == MODE_PUSH_BACK);
    assign out_stall   = m_valid && !m_ready;
    assign err_out     = m_valid && (m_status != ST_OK);
    assign list_mid    = m_valid && !m_last;
    assign out_payload = {m_element, m_status, m_last};

    // Stalled result holds
    `DQ_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_valid && $stable(out_payload))

    // Any non-ok result closes its transaction and carries no element
    `DQ_ASSERT_NOW(a_err_last, aclk, aresetn, err_out, m_last && m_element == '0)

    // A push answers in the following cycle with a single result
    `DQ_ASSERT_NEXT(a_push_resp, aclk, aresetn, push_take, m_valid && m_last && m_element == '0)

    // No new transaction is taken in the middle of a listing
    `DQ_ASSERT_NOW(a_list_busy, aclk, aresetn, list_mid, !s_ready)

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);
